// File: rtl/core/sensor_command_line_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command line parser core
// Clocked property wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_LINE_PARSER_CORE_ASSERT_SVH
`define SENSOR_COMMAND_LINE_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge, off while reset is asserted.
`define SCL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scl assertion failed");

// Property checked on every rising edge, also during reset.
`define SCL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scl assertion failed");

`else

`define SCL_ASSERT(lbl, clk, rst_n, prop)
`define SCL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Command codes, command word table and line match state type.
// ----------------------------------------------------------------------------
package scl_pkg;

    typedef enum logic [2:0] {
        CMD_OFF     = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_SCALE_F = 3'd3,
        CMD_SCALE_C = 3'd4,
        CMD_PERIOD  = 3'd5,
        CMD_LOG     = 3'd6,
        CMD_INVALID = 3'd7
    } cmd_code_t;

    localparam int          WORD_COUNT   = 7;
    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [3:0]  DIGITS_START = 4'd7;
    localparam logic [3:0]  POS_MAX      = 4'd15;

    // Position in the line and one still-matching flag per command word.
    typedef struct packed {
        logic [3:0]            pos;
        logic [WORD_COUNT-1:0] flags;
    } line_match_t;

    // Command word text, first character in the top byte, zero padded.
    function automatic logic [55:0] word_text(input logic [2:0] k);
        logic [55:0] w;
        unique case (k)
            3'd0:    w = {"OFF", 32'd0};
            3'd1:    w = {"START", 16'd0};
            3'd2:    w = {"STOP", 24'd0};
            3'd3:    w = "SCALE=F";
            3'd4:    w = "SCALE=C";
            3'd5:    w = "PERIOD=";
            3'd6:    w = {"LOG", 32'd0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] k, input logic [2:0] pos);
        logic [55:0] w;
        w = word_text(k);
        return w[55 - 8*pos -: 8];
    endfunction

    function automatic logic [3:0] word_len(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            3'd0:    n = 4'd3;
            3'd1:    n = 4'd5;
            3'd2:    n = 4'd4;
            3'd6:    n = 4'd3;
            default: n = 4'd7;
        endcase
        return n;
    endfunction

    // OFF, START and STOP must match the whole line; the rest are prefixes.
    function automatic logic word_exact(input logic [2:0] k);
        return (k == 3'd0) || (k == 3'd1) || (k == 3'd2);
    endfunction

endpackage

// File: rtl/core/scl_line_tracker.sv
// ----------------------------------------------------------------------------
// scl_line_tracker
// Per-byte match state: position, word flags and PERIOD= digit value.
// ----------------------------------------------------------------------------
module scl_line_tracker #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       clear,
    input  logic [7:0]                 rx_byte,
    output scl_pkg::line_match_t       line_state,
    output logic [PERIOD_WIDTH-1:0]    digit_value
);

`include "sensor_command_line_parser_core_assert.svh"

    localparam int EXT_WIDTH = PERIOD_WIDTH + 4;

    logic [3:0]                     pos_reg, pos_next;
    logic [scl_pkg::WORD_COUNT-1:0] flags_reg, flags_next, keep;
    logic [PERIOD_WIDTH-1:0]        digit_reg, digit_next;
    logic                           ended_reg, ended_next;
    logic [EXT_WIDTH-1:0]           ext, acc;
    logic [3:0]                     dig;
    logic                           is_digit;

    // One compare per word, independent of each other.
    always_comb
    begin
        for (int k = 0; k < scl_pkg::WORD_COUNT; k++)
        begin
            keep[k] = !((pos_reg < scl_pkg::word_len(3'(k))) &&
                        (rx_byte != scl_pkg::word_char(3'(k), pos_reg[2:0])));
        end
    end

    assign is_digit = (rx_byte >= scl_pkg::CHAR_ZERO) && (rx_byte <= scl_pkg::CHAR_NINE);
    assign dig      = 4'(rx_byte - scl_pkg::CHAR_ZERO);
    assign ext      = {4'd0, digit_reg};
    // value * 10 + digit, saturating below
    assign acc      = (ext << 3) + (ext << 1) + EXT_WIDTH'(dig);

    always_comb
    begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        digit_next = digit_reg;
        ended_next = ended_reg;
        if (clear)
        begin
            pos_next   = '0;
            flags_next = '1;
            digit_next = '0;
            ended_next = 1'b0;
        end
        else if (step)
        begin
            flags_next = flags_reg & keep;
            if (!ended_reg && (pos_reg >= scl_pkg::DIGITS_START))
            begin
                if (is_digit)
                begin
                    if (acc[EXT_WIDTH-1 -: 4] != 4'd0)
                        digit_next = '1;
                    else
                        digit_next = acc[PERIOD_WIDTH-1:0];
                end
                else
                begin
                    ended_next = 1'b1;
                end
            end
            if (pos_reg != scl_pkg::POS_MAX)
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '1;
            digit_reg <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            digit_reg <= digit_next;
            ended_reg <= ended_next;
        end
    end

    assign line_state.pos   = pos_reg;
    assign line_state.flags = flags_reg;
    assign digit_value      = digit_reg;

    `SCL_ASSERT(a_pos_saturates, clk, rst_n,
        (pos_reg == scl_pkg::POS_MAX) && step && !clear |=> pos_reg == scl_pkg::POS_MAX)
    `SCL_ASSERT(a_flags_only_drop, clk, rst_n,
        !clear |=> (flags_reg & ~$past(flags_reg)) == '0)
    `SCL_ASSERT(a_digits_stop, clk, rst_n,
        ended_reg && !clear |=> digit_reg == $past(digit_reg))

endmodule

// File: rtl/core/scl_classify.sv
// ----------------------------------------------------------------------------
// scl_classify
// Picks the first command word whose flag and length agree with the line.
// ----------------------------------------------------------------------------
module scl_classify (
    input  scl_pkg::line_match_t line_state,
    output scl_pkg::cmd_code_t   code
);

    logic [scl_pkg::WORD_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < scl_pkg::WORD_COUNT; k++)
        begin
            if (scl_pkg::word_exact(3'(k)))
                hit[k] = line_state.flags[k] && (line_state.pos == scl_pkg::word_len(3'(k)));
            else
                hit[k] = line_state.flags[k] && (line_state.pos >= scl_pkg::word_len(3'(k)));
        end
    end

    // Lowest word index wins.
    always_comb
    begin
        code = scl_pkg::CMD_INVALID;
        for (int k = scl_pkg::WORD_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
                code = scl_pkg::cmd_code_t'(3'(k));
        end
    end

endmodule

// File: rtl/core/sensor_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// sensor_command_line_parser_core
// Streaming command line matcher that classifies each line at newline.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  rx       in   rx_valid/rx_stall  rx_byte
//  res      out  res_valid/res_stall command_code, running, scale_celsius,
//                                   period_seconds
//
// One byte per cycle sustained while rx_stall is low. A byte is registered in
// the input register, where the match state is updated (or the line classified
// on newline); a result is then registered in the output register. rx_stall
// rises only when a newline waits in the input register while the output
// register is full and stalled. Reset: running on, Fahrenheit, period 1, line
// cleared. After OFF or an invalid line all bytes are taken and dropped until
// reset.
// ----------------------------------------------------------------------------
module sensor_command_line_parser_core #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  command_code,
    output logic        running,
    output logic        scale_celsius,
    output logic [15:0] period_seconds
);

`include "sensor_command_line_parser_core_assert.svh"

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;

    // Settings
    logic                    running_reg, running_next;
    logic                    celsius_reg, celsius_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic                    halted_reg, halted_next;

    // Output register
    logic               res_valid_reg, res_valid_next;
    scl_pkg::cmd_code_t res_code_reg, res_code_next;
    logic               res_running_reg, res_running_next;
    logic               res_celsius_reg, res_celsius_next;
    logic [15:0]        res_period_reg, res_period_next;

    logic                    is_newline, out_free, hold, fire, step, line_end;
    scl_pkg::line_match_t    line_state;
    logic [PERIOD_WIDTH-1:0] digit_value;
    scl_pkg::cmd_code_t      code;
    logic [15:0]             period16;

    assign is_newline = (in_byte_reg == scl_pkg::CHAR_NEWLINE);
    assign out_free   = !res_valid_reg || !res_stall;
    // A newline can only be classified when its result has a place to go.
    assign hold       = in_valid_reg && !halted_reg && is_newline && !out_free;
    assign fire       = in_valid_reg && !hold;
    assign step       = fire && !halted_reg && !is_newline;
    assign line_end   = fire && !halted_reg && is_newline;
    assign rx_stall   = hold;

    scl_line_tracker #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .clear       (line_end),
        .rx_byte     (in_byte_reg),
        .line_state  (line_state),
        .digit_value (digit_value)
    );

    scl_classify u_classify (
        .line_state (line_state),
        .code       (code)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (!hold)
        begin
            in_valid_next = rx_valid;
            in_byte_next  = rx_byte;
        end
    end

    // Settings after this line's command.
    always_comb
    begin
        running_next = running_reg;
        celsius_next = celsius_reg;
        period_next  = period_reg;
        halted_next  = halted_reg;
        if (line_end)
        begin
            unique case (code)
                scl_pkg::CMD_OFF:     halted_next  = 1'b1;
                scl_pkg::CMD_START:   running_next = 1'b1;
                scl_pkg::CMD_STOP:    running_next = 1'b0;
                scl_pkg::CMD_SCALE_F: celsius_next = 1'b0;
                scl_pkg::CMD_SCALE_C: celsius_next = 1'b1;
                scl_pkg::CMD_PERIOD:  period_next  = digit_value;
                scl_pkg::CMD_LOG:     halted_next  = halted_reg;
                scl_pkg::CMD_INVALID: halted_next  = 1'b1;
            endcase
        end
    end

    // Reported period is the low 16 bits of the stored period.
    generate
        if (PERIOD_WIDTH >= 16)
        begin : g_period_wide
            assign period16 = period_next[15:0];
        end
        else
        begin : g_period_narrow
            assign period16 = {{(16-PERIOD_WIDTH){1'b0}}, period_next};
        end
    endgenerate

    always_comb
    begin
        res_valid_next   = res_valid_reg && res_stall;
        res_code_next    = res_code_reg;
        res_running_next = res_running_reg;
        res_celsius_next = res_celsius_reg;
        res_period_next  = res_period_reg;
        if (line_end)
        begin
            res_valid_next   = 1'b1;
            res_code_next    = code;
            res_running_next = running_next;
            res_celsius_next = celsius_next;
            res_period_next  = period16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            running_reg   <= 1'b1;
            celsius_reg   <= 1'b0;
            period_reg    <= PERIOD_WIDTH'(1);
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            running_reg   <= running_next;
            celsius_reg   <= celsius_next;
            period_reg    <= period_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg     <= in_byte_next;
        res_code_reg    <= res_code_next;
        res_running_reg <= res_running_next;
        res_celsius_reg <= res_celsius_next;
        res_period_reg  <= res_period_next;
    end

    assign res_valid      = res_valid_reg;
    assign command_code   = res_code_reg;
    assign running        = res_running_reg;
    assign scale_celsius  = res_celsius_reg;
    assign period_seconds = res_period_reg;

    `SCL_ASSERT(a_halt_sticky, clk, rst_n, halted_reg |=> halted_reg)
    `SCL_ASSERT(a_no_result_when_halted, clk, rst_n,
        halted_reg && !res_valid_reg |=> !res_valid_reg)
    `SCL_ASSERT(a_stall_cause, clk, rst_n,
        rx_stall |-> res_valid_reg && res_stall && in_valid_reg && is_newline)
    `SCL_ASSERT(a_off_invalid_halts, clk, rst_n,
        line_end && (code == scl_pkg::CMD_OFF || code == scl_pkg::CMD_INVALID)
        |=> halted_reg)

endmodule

// File: tb/sv/sensor_command_line_parser_core_checker.sv
// ----------------------------------------------------------------------------
// sensor_command_line_parser_core_checker
// Watches both channels, tracks the line match state and checks each result.
// ----------------------------------------------------------------------------
module sensor_command_line_parser_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [2:0]  command_code,
    input  logic        running,
    input  logic        scale_celsius,
    input  logic [15:0] period_seconds,
    output int          error_count,
    output int          pending_results,
    output int          results_seen,
    output logic [7:0]  codes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PERIOD_MAX = (1 << 16) - 1;
    localparam int          REPORT_MAX = 10;

    // Keyword k sits at index k, first character in the top byte.
    localparam logic [6:0][55:0] KEYWORD_TEXT = {
        {"LOG", 32'd0}, "PERIOD=", "SCALE=C", "SCALE=F",
        {"STOP", 24'd0}, {"START", 16'd0}, {"OFF", 32'd0}
    };
    localparam logic [6:0][3:0] KEYWORD_LEN = {
        4'd3, 4'd7, 4'd7, 4'd7, 4'd4, 4'd5, 4'd3
    };

    typedef struct packed {
        scl_pkg::cmd_code_t code;
        logic               run_on;
        logic               celsius;
        logic [15:0]        period;
    } line_status_t;

    // Line and settings state
    logic [3:0]   line_pos;
    logic [6:0]   still_matching;
    logic [15:0]  period_digits;
    logic         digits_done;
    logic         run_on;
    logic         in_celsius;
    logic [15:0]  period_now;
    logic         halted;

    line_status_t status_due[$];
    line_status_t oldest;

    task automatic clear_line_state();
        line_pos       = '0;
        still_matching = '1;
        period_digits  = '0;
        digits_done    = 1'b0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        int                 k;
        int                 p;
        int unsigned        acc;
        scl_pkg::cmd_code_t code;
        line_status_t       st;
        p = line_pos;
        if (halted)
            return;
        if (b != scl_pkg::CHAR_NEWLINE)
        begin
            for (k = 0; k < scl_pkg::WORD_COUNT; k++)
            begin
                if (line_pos < KEYWORD_LEN[k] && b != KEYWORD_TEXT[k][55 - 8*p -: 8])
                    still_matching[k] = 1'b0;
            end
            if (!digits_done && line_pos >= scl_pkg::DIGITS_START)
            begin
                if (b >= scl_pkg::CHAR_ZERO && b <= scl_pkg::CHAR_NINE)
                begin
                    acc = period_digits * 10 + (b - scl_pkg::CHAR_ZERO);
                    if (acc > PERIOD_MAX)
                        acc = PERIOD_MAX;
                    period_digits = acc[15:0];
                end
                else
                begin
                    digits_done = 1'b1;
                end
            end
            if (line_pos < scl_pkg::POS_MAX)
                line_pos = line_pos + 4'd1;
        end
        else
        begin
            // lowest keyword index wins; exact words need the full length
            code = scl_pkg::CMD_INVALID;
            for (k = scl_pkg::WORD_COUNT - 1; k >= 0; k--)
            begin
                if (still_matching[k] &&
                    ((k < int'(scl_pkg::CMD_SCALE_F)) ? (line_pos == KEYWORD_LEN[k])
                                                      : (line_pos >= KEYWORD_LEN[k])))
                    code = scl_pkg::cmd_code_t'(k);
            end
            case (code)
                scl_pkg::CMD_START:   run_on = 1'b1;
                scl_pkg::CMD_STOP:    run_on = 1'b0;
                scl_pkg::CMD_SCALE_F: in_celsius = 1'b0;
                scl_pkg::CMD_SCALE_C: in_celsius = 1'b1;
                scl_pkg::CMD_PERIOD:  period_now = period_digits;
                scl_pkg::CMD_OFF, scl_pkg::CMD_INVALID: halted = 1'b1;
                default: ;
            endcase
            st.code    = code;
            st.run_on  = run_on;
            st.celsius = in_celsius;
            st.period  = period_now;
            status_due.push_back(st);
            clear_line_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line_state();
            run_on          = 1'b1;
            in_celsius      = 1'b0;
            period_now      = 16'd1;
            halted          = 1'b0;
            status_due.delete();
            error_count     = 0;
            pending_results = 0;
            results_seen    = 0;
            codes_seen      = '0;
        end
        else
        begin
            // result first: it can never belong to a byte taken at this edge
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (status_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: unexpected result code %0d run %0b celsius %0b period %0d",
                                 $realtime, command_code, running, scale_celsius,
                                 period_seconds);
                end
                else
                begin
                    oldest = status_due.pop_front();
                    codes_seen[oldest.code] = 1'b1;
                    if (command_code !== oldest.code || running !== oldest.run_on ||
                        scale_celsius !== oldest.celsius || period_seconds !== oldest.period)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                        begin
                            $display("%0t: result %0d expected code %0d run %0b celsius %0b period %0d",
                                     $realtime, results_seen, oldest.code, oldest.run_on,
                                     oldest.celsius, oldest.period);
                            $display("%0t: result %0d got code %0d run %0b celsius %0b period %0d",
                                     $realtime, results_seen, command_code, running,
                                     scale_celsius, period_seconds);
                        end
                    end
                end
            end
            if (rx_valid && !rx_stall)
                parse_rx_byte(rx_byte);
            pending_results = status_due.size();
        end
    end

endmodule

// File: tb/sv/sensor_command_line_parser_core_tb.sv
// ----------------------------------------------------------------------------
// sensor_command_line_parser_core_tb
// Feeds command lines byte by byte with random gaps and output stalls;
// a separate checker predicts and compares every line result.
// ----------------------------------------------------------------------------
module sensor_command_line_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Slowest legal run: ~1400 bytes, each after its longest idle gap plus a full
    // output stall, stays well under CYCLE_LIMIT.
    localparam int ITEM_TARGET  = 1200;
    localparam int MAX_IDLE     = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    // Only one line can stop the parser, since reset happens once: the run
    // ends with one of these.
    typedef enum int {
        CLOSE_OFF,
        CLOSE_EMPTY,
        CLOSE_NEAR_MISS,
        CLOSE_GARBAGE
    } closing_line_t;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_stall;
    logic [2:0]  command_code;
    logic        running;
    logic        scale_celsius;
    logic [15:0] period_seconds;

    int          error_count;
    int          pending_results;
    int          results_seen;
    logic [7:0]  codes_seen;

    logic [7:0]    line_bytes[$];   // line under construction, newline excluded
    int            bytes_sent;
    int            bytes_before_close;
    int            cycle_count;
    logic          rx_no_gaps;      // back-to-back stretch on the input side
    logic          res_no_stalls;   // always-ready stretch on the output side
    closing_line_t close_kind;

    sensor_command_line_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .command_code   (command_code),
        .running        (running),
        .scale_celsius  (scale_celsius),
        .period_seconds (period_seconds)
    );

    sensor_command_line_parser_core_checker line_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .command_code    (command_code),
        .running         (running),
        .scale_celsius   (scale_celsius),
        .period_seconds  (period_seconds),
        .error_count     (error_count),
        .pending_results (pending_results),
        .results_seen    (results_seen),
        .codes_seen      (codes_seen)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("sensor_command_line_parser_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Line building helpers
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    // Any byte value but newline, so the suffix never closes the line.
    task automatic add_noise(input int count);
        int   i;
        logic [7:0] b;
        for (i = 0; i < count; i++)
        begin
            b = 8'($urandom_range(0, 254));
            if (b >= scl_pkg::CHAR_NEWLINE)
                b = b + 8'd1;
            line_bytes.push_back(b);
        end
    endtask

    task automatic add_digits(input int count);
        int i;
        for (i = 0; i < count; i++)
            line_bytes.push_back(scl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // ------------------------------------------------------------------
    // Input side: one item per call. Each item draws its own idle gap;
    // with no gap, valid stays high and only the payload moves on.
    // Called and returns at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        // taken at the first rising edge with stall low
        do
            @(posedge clk);
        while (rx_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        int i;
        rx_no_gaps = ($urandom_range(0, 3) == 0);
        for (i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i]);
        send_byte(scl_pkg::CHAR_NEWLINE);
        line_bytes.delete();
    endtask

    task automatic send_text_line(input string s);
        add_text(s);
        send_line();
    endtask

    // A well-formed command with random content: exact words bare, prefix
    // words with an arbitrary tail, period values of every shape.
    task automatic build_random_line();
        scl_pkg::cmd_code_t cmd;
        int                 style;
        string              lead;
        lead = " +-";
        cmd  = scl_pkg::cmd_code_t'($urandom_range(scl_pkg::CMD_START, scl_pkg::CMD_LOG));
        case (cmd)
            scl_pkg::CMD_START: add_text("START");
            scl_pkg::CMD_STOP:  add_text("STOP");
            scl_pkg::CMD_SCALE_F:
            begin
                add_text("SCALE=F");
                if ($urandom_range(0, 1))
                    add_noise($urandom_range(1, 10));
            end
            scl_pkg::CMD_SCALE_C:
            begin
                add_text("SCALE=C");
                if ($urandom_range(0, 1))
                    add_noise($urandom_range(1, 10));
            end
            scl_pkg::CMD_PERIOD:
            begin
                add_text("PERIOD=");
                style = $urandom_range(0, 9);
                if (style == 0)
                begin
                    // sign or space right after '=' forces zero
                    line_bytes.push_back(lead[$urandom_range(0, 2)]);
                    add_digits($urandom_range(0, 4));
                end
                else if (style == 1)
                begin
                    // leading zeros push the digits past the position limit
                    repeat ($urandom_range(6, 12)) line_bytes.push_back(scl_pkg::CHAR_ZERO);
                    add_digits($urandom_range(1, 5));
                end
                else if (style == 2)
                begin
                    add_digits($urandom_range(6, 10));
                end
                else
                begin
                    add_digits($urandom_range(0, 5));
                end
                if ($urandom_range(0, 2) == 0)
                    add_noise($urandom_range(1, 6));
            end
            default:
            begin
                add_text("LOG");
                add_noise($urandom_range(0, 12));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: a random stall before each result, with
    // stretches of no stalls at all.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        res_stall     = 1'b0;
        res_no_stalls = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = res_no_stalls ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(res_valid && !res_stall));
            @(negedge clk);
            if ($urandom_range(0, 7) == 0)
                res_no_stalls = !res_no_stalls;
        end
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        rx_no_gaps = 1'b0;
        bytes_sent = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines: every command but OFF, period edge values,
        // sign and space after '=', no digits, digits cut short by a letter,
        // digits running past the position limit, and a long tail of
        // NUL, CR and high-bit bytes after a prefix word.
        send_text_line("STOP");
        send_text_line("START");
        send_text_line("SCALE=C");
        send_text_line("SCALE=Fahrenheit");
        send_text_line("LOG");
        send_text_line("PERIOD=65535");
        send_text_line("PERIOD=65536");
        send_text_line("PERIOD=-3");
        send_text_line("PERIOD= 8");
        send_text_line("PERIOD=");
        send_text_line("PERIOD=12x34");
        send_text_line("PERIOD=0000000000000250");
        send_text_line("SCALE=Celsius");
        add_text("LOG");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'h0D);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h80);
        line_bytes.push_back(8'h7F);
        line_bytes.push_back(8'h01);
        add_noise(12);
        send_line();

        // Random well-formed lines
        while (bytes_sent < ITEM_TARGET)
        begin
            build_random_line();
            send_line();
        end

        // The one line that stops the parser
        bytes_before_close = bytes_sent;
        close_kind = closing_line_t'($urandom_range(CLOSE_OFF, CLOSE_GARBAGE));
        case (close_kind)
            CLOSE_OFF:   add_text("OFF");
            CLOSE_EMPTY: ;
            CLOSE_NEAR_MISS:
            begin
                case ($urandom_range(0, 2))
                    0: add_text("START\r");
                    1: add_text("OF");
                    default: add_text("STOPX");
                endcase
            end
            default:     add_noise($urandom_range(1, 8));
        endcase
        send_line();

        // Everything after the stop must be swallowed without a result.
        send_text_line("START");
        add_noise($urandom_range(1, 8));
        send_line();
        rx_valid <= 1'b0;

        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d before the closing line), %0d line results checked.",
                 bytes_sent, bytes_before_close, results_seen);
        $display("Result codes seen %b, closing line %s.", codes_seen, close_kind.name());
        if (error_count == 0)
        begin
            $display("sensor_command_line_parser_core verification clean");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("sensor_command_line_parser_core verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/scl_pkg.sv
rtl/core/scl_line_tracker.sv
rtl/core/scl_classify.sv
rtl/core/sensor_command_line_parser_core.sv
tb/sv/sensor_command_line_parser_core_checker.sv
tb/sv/sensor_command_line_parser_core_tb.sv
